// ----- rtl/tqs_pkg.sv -----
// Shared types, codes and helpers for the timed event queue scheduler.
`timescale 1ns / 1ps
package tqs_pkg;

  typedef enum logic [2:0] {
    F_SCHEDULE    = 3'd0,
    F_CANCEL_USER = 3'd1,
    F_CANCEL_KIND = 3'd2,
    F_ADD_TICKS   = 3'd3,
    F_IDLE        = 3'd4,
    F_ADVANCE     = 3'd5,
    F_FORCE       = 3'd6,
    F_CLEAR       = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_IN,
    ST_DUE,
    ST_INS,
    ST_CANCEL,
    ST_IDLE1,
    ST_IDLE2,
    ST_ADV,
    ST_STATUS
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_CANCEL,
    CELL_POP,
    CELL_CLR
  } cell_op_t;

  typedef struct packed {
    logic [63:0] due;
    logic [5:0]  kind;
    logic [63:0] user;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   ent;      // new entry for insert, match key for cancel
    logic     by_kind;  // cancel ignores the user word
  } cell_ctl_t;

  localparam logic [30:0] MAX_SLICE_RESET = 31'd20000;

  // Times compare as signed 64-bit values.
  function automatic logic time_le(input logic [63:0] a, input logic [63:0] b);
    time_le = $signed(a) <= $signed(b);
  endfunction

endpackage

// ----- rtl/tqs_cell.sv -----
// One queue slot of the sorted event chain.
`timescale 1ns / 1ps
module tqs_cell (
  input  logic             clk,
  input  logic             rst,
  input  tqs_pkg::cell_ctl_t ctl,
  input  tqs_pkg::entry_t  left_ent,
  input  logic             left_valid,
  input  logic             left_gt,
  input  tqs_pkg::entry_t  right_ent,
  input  logic             right_valid,
  input  logic             found_in,
  output tqs_pkg::entry_t  ent,
  output logic             valid,
  output logic             gt,
  output logic             found_out
);
  import tqs_pkg::*;

  logic match;

  assign gt = valid && !time_le(ent.due, ctl.ent.due);
  assign match = valid && (ent.kind == ctl.ent.kind) &&
                 (ctl.by_kind || (ent.user == ctl.ent.user));
  assign found_out = found_in || match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctl.op)
        CELL_INS: begin
          if (left_gt) begin
            ent   <= left_ent;
            valid <= left_valid;
          end else if ((!valid || gt) && left_valid) begin
            ent   <= ctl.ent;
            valid <= 1'b1;
          end
        end
        CELL_CANCEL: begin
          if (found_out) begin
            ent   <= right_ent;
            valid <= right_valid;
          end
        end
        CELL_POP: begin
          ent   <= right_ent;
          valid <= right_valid;
        end
        CELL_CLR: valid <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/timed_event_queue_scheduler.sv -----
// Top level: command sequencer, time state and output register over the event chain.
// Steps: add ticks, force, clear and dropped schedules go straight to STATUS; cancel via
// CANCEL, schedule DUE then INS, idle IDLE1 then IDLE2; advance pops each due event.
// One request at a time; the sequencer loop and the output register set the rate.
// Output stalls hold the sequencer; results are never dropped.
// Reset (rst, synchronous) empties the queue, zeroes time and idle sum, slice = 20000.
`timescale 1ns / 1ps
module timed_event_queue_scheduler #(
  parameter int QUEUE_DEPTH     = 16,
  parameter int NUM_EVENT_KINDS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // delay_cycles, event_kind, user_word, tick_count, idle_limit, zero pad
  input  logic [167:0] s_tdata,
  // func
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // fired_kind, fired_user, late_cycles, tick_now, downcount_now, idle_total,
  // queue_full, zero pad
  output logic [263:0] m_tdata,
  // result_kind
  output logic         m_tuser,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [30:0]  cfg_data
);
  import tqs_pkg::*;

  state_t state, state_next;
  cell_ctl_t ctl;

  func_t        func_r;
  logic [31:0]  delay_r;
  logic [5:0]   kind_r;
  logic [63:0]  user_r;
  logic [30:0]  limit_r;
  logic         full_r;
  logic [63:0]  cur_r;
  logic [63:0]  due_r;
  logic [30:0]  dc_r;
  logic signed [34:0] gap_r;
  logic         head_v_r;

  logic [63:0]  global_ticks;
  logic signed [31:0] slice_ticks;
  logic signed [31:0] ticks_left;
  logic [63:0]  idle_sum;
  logic [30:0]  max_slice;

  entry_t ent_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_gt;
  logic [QUEUE_DEPTH:0]   found;

  logic accept, out_free, fire, full_now, load_out;
  logic signed [32:0] exec_diff;
  logic [63:0] cur_ticks;
  func_t in_func;

  assign in_func   = func_t'(s_tuser);
  assign s_tready  = (state == ST_IN);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign full_now  = cell_valid[QUEUE_DEPTH-1];
  assign exec_diff = $signed({slice_ticks[31], slice_ticks}) -
                     $signed({ticks_left[31], ticks_left});
  assign cur_ticks = global_ticks + {{31{exec_diff[32]}}, exec_diff};
  assign fire      = cell_valid[0] && time_le(ent_q[0].due, global_ticks);
  assign load_out  = out_free && ((state == ST_ADV && fire) || state == ST_STATUS);
  assign found[0]  = 1'b0;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      entry_t le_ent, ri_ent;
      logic   le_valid, le_gt, ri_valid;
      if (g == 0) begin : g_first
        assign le_ent   = ent_q[0];
        assign le_valid = 1'b1;
        assign le_gt    = 1'b0;
      end else begin : g_mid
        assign le_ent   = ent_q[g-1];
        assign le_valid = cell_valid[g-1];
        assign le_gt    = cell_gt[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_last
        assign ri_ent   = ent_q[g];
        assign ri_valid = 1'b0;
      end else begin : g_inner
        assign ri_ent   = ent_q[g+1];
        assign ri_valid = cell_valid[g+1];
      end
      tqs_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .left_ent   (le_ent),
        .left_valid (le_valid),
        .left_gt    (le_gt),
        .right_ent  (ri_ent),
        .right_valid(ri_valid),
        .found_in   (found[g]),
        .ent        (ent_q[g]),
        .valid      (cell_valid[g]),
        .gt         (cell_gt[g]),
        .found_out  (found[g+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctl.op        = CELL_HOLD;
    ctl.ent.due   = due_r;
    ctl.ent.kind  = kind_r;
    ctl.ent.user  = user_r;
    ctl.by_kind   = (func_r == F_CANCEL_KIND);
    unique case (state)
      ST_IN: begin
        if (accept) begin
          unique case (in_func)
            F_SCHEDULE: begin
              if (32'(s_tdata[37:32]) < NUM_EVENT_KINDS && !full_now) begin
                state_next = ST_DUE;
              end else begin
                state_next = ST_STATUS;
              end
            end
            F_CANCEL_USER, F_CANCEL_KIND: state_next = ST_CANCEL;
            F_IDLE:    state_next = ST_IDLE1;
            F_ADVANCE: state_next = ST_ADV;
            F_CLEAR: begin
              ctl.op     = CELL_CLR;
              state_next = ST_STATUS;
            end
            default: state_next = ST_STATUS;
          endcase
        end
      end
      ST_DUE: state_next = ST_INS;
      ST_INS: begin
        ctl.op     = CELL_INS;
        state_next = ST_STATUS;
      end
      ST_CANCEL: begin
        ctl.op     = CELL_CANCEL;
        state_next = ST_STATUS;
      end
      ST_IDLE1: state_next = ST_IDLE2;
      ST_IDLE2: state_next = ST_STATUS;
      ST_ADV: begin
        if (fire) begin
          if (out_free) begin
            ctl.op = CELL_POP;
          end
        end else begin
          state_next = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          state_next = ST_IN;
        end
      end
      default: state_next = ST_IN;
    endcase
  end

  // Datapath and time state
  logic signed [32:0] sub_v;
  logic signed [31:0] dc_clip;
  logic signed [64:0] due_diff;
  logic signed [34:0] sum_v;
  logic signed [35:0] rem_v;
  logic [30:0] dc_fin;
  logic [63:0] head_gap;
  logic [31:0] slice_new;
  logic [63:0] late_full;

  always_comb begin
    sub_v = $signed({ticks_left[31], ticks_left}) - $signed({2'b00, s_tdata[132:102]});
    dc_clip = ticks_left;
    if (limit_r != 31'd0 && ticks_left > $signed({1'b0, limit_r})) begin
      dc_clip = $signed({1'b0, limit_r});
    end
    if (dc_clip < 0) begin
      dc_clip = '0;
    end
    due_diff = $signed({ent_q[0].due[63], ent_q[0].due}) -
               $signed({global_ticks[63], global_ticks});
    sum_v  = 35'(exec_diff) + $signed({4'b0000, dc_r});
    rem_v  = 36'(gap_r) - 36'(exec_diff);
    dc_fin = dc_r;
    if (head_v_r && dc_r != 31'd0 && gap_r < sum_v) begin
      dc_fin = (rem_v < 0) ? 31'd0 : rem_v[30:0];
    end
    head_gap  = ent_q[0].due - global_ticks;
    slice_new = {1'b0, max_slice};
    if (cell_valid[0] && head_gap < {33'd0, max_slice}) begin
      slice_new = head_gap[31:0];
    end
    late_full = global_ticks - ent_q[0].due;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      global_ticks <= '0;
      slice_ticks  <= $signed({1'b0, MAX_SLICE_RESET});
      ticks_left   <= $signed({1'b0, MAX_SLICE_RESET});
      idle_sum     <= '0;
      max_slice    <= MAX_SLICE_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_slice <= cfg_data;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IN: begin
          if (accept) begin
            func_r  <= in_func;
            delay_r <= s_tdata[31:0];
            kind_r  <= s_tdata[37:32];
            user_r  <= s_tdata[101:38];
            limit_r <= s_tdata[163:133];
            full_r  <= (in_func == F_SCHEDULE) && full_now &&
                       (32'(s_tdata[37:32]) < NUM_EVENT_KINDS);
            cur_r   <= cur_ticks;
            case (in_func)
              F_ADD_TICKS: begin
                ticks_left <= (sub_v < -33'sd2147483648) ? 32'sh80000000 : sub_v[31:0];
              end
              F_ADVANCE: global_ticks <= cur_ticks;
              F_FORCE: begin
                global_ticks <= cur_ticks;
                ticks_left   <= -32'sd1;
                slice_ticks  <= -32'sd1;
              end
              default: ;
            endcase
          end
        end
        ST_DUE: due_r <= cur_r + {{32{delay_r[31]}}, delay_r};
        ST_IDLE1: begin
          dc_r     <= dc_clip[30:0];
          head_v_r <= cell_valid[0];
          if (due_diff > 65'sd8589934592) begin
            gap_r <= 35'sd8589934592;
          end else if (due_diff < -65'sd8589934592) begin
            gap_r <= -35'sd8589934592;
          end else begin
            gap_r <= due_diff[34:0];
          end
        end
        ST_IDLE2: begin
          idle_sum   <= idle_sum + {33'd0, dc_fin};
          ticks_left <= ticks_left - $signed({1'b0, dc_fin});
        end
        ST_ADV: begin
          if (fire) begin
            if (out_free) begin
              m_tuser  <= 1'b1;
              m_tlast  <= 1'b0;
              m_tdata  <= {1'b0, 1'b0, idle_sum, 32'd0, global_ticks,
                           (late_full[63:32] != 32'd0) ? 32'hFFFFFFFF : late_full[31:0],
                           ent_q[0].user, ent_q[0].kind};
            end
          end else begin
            slice_ticks <= slice_new;
            ticks_left  <= slice_new;
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            m_tuser  <= 1'b0;
            m_tlast  <= 1'b1;
            m_tdata  <= {1'b0, full_r, idle_sum, ticks_left, cur_ticks,
                         32'd0, 64'd0, 6'd0};
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_packed: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid + 1'b1) & cell_valid) == '0)
    else $error("queue entries not packed at the front");
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    cell_valid[1] |-> time_le(ent_q[0].due, ent_q[1].due))
    else $error("queue head out of time order");
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tlast)
    else $error("fired result marked last");
  a_pop_needs_fire: assert property (@(posedge clk) disable iff (rst)
    ctl.op == CELL_POP |-> fire && out_free)
    else $error("head popped without a due event");
`endif

endmodule

// ----- bench/tb_timed_event_queue_scheduler.sv -----
// Testbench for the timed event queue scheduler: random and directed requests, checked results.
`timescale 1ns / 1ps
module tb_timed_event_queue_scheduler;
  import tqs_pkg::*;

  localparam int DEPTH = 16;
  localparam longint GAP_LIMIT = 64'sh2_0000_0000;

  typedef struct {
    func_t        fn;
    logic [167:0] payload;
  } request_t;

  typedef struct {
    logic        rkind;
    logic [5:0]  kind;
    logic [63:0] user;
    logic [31:0] late;
    logic [63:0] tick;
    logic [31:0] dcount;
    logic [63:0] idle;
    logic        full;
    logic        last;
  } sched_result_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [263:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [30:0]  cfg_data = '0;

  request_t      pending_reqs[$];
  sched_result_t expected_results[$];
  int            errors = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  // scheduler state mirror
  logic [63:0] ev_due[DEPTH];
  logic [5:0]  ev_kind[DEPTH];
  logic [63:0] ev_user[DEPTH];
  int          ev_count;
  logic [63:0] global_ticks;
  int          slice_ticks;
  int          ticks_left;
  logic [63:0] idle_sum;
  logic [30:0] max_slice;

  timed_event_queue_scheduler uut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] tick_now();
    return global_ticks + 64'(longint'(slice_ticks) - longint'(ticks_left));
  endfunction

  function automatic void push_result(logic rk, logic [5:0] k, logic [63:0] u, logic [31:0] lt,
                                      logic [63:0] t, int dc, logic full, logic last);
    sched_result_t r;
    r.rkind = rk; r.kind = k; r.user = u; r.late = lt; r.tick = t;
    r.dcount = dc; r.idle = idle_sum; r.full = full; r.last = last;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void drop_event(int pos);
    for (int i = pos; i + 1 < ev_count; i++) begin
      ev_due[i] = ev_due[i+1]; ev_kind[i] = ev_kind[i+1]; ev_user[i] = ev_user[i+1];
    end
    ev_count--;
  endfunction

  function automatic void predict_request(request_t rq);
    logic signed [31:0] delay;
    logic [5:0]  kind;
    logic [63:0] user, due, d;
    longint      tcount, limit, v, dc, done, gap;
    int          pos;
    logic        full;
    delay = rq.payload[31:0];
    kind = rq.payload[37:32];
    user = rq.payload[101:38];
    tcount = longint'(rq.payload[132:102]);
    limit = longint'(rq.payload[163:133]);
    full = 0;
    case (rq.fn)
      F_SCHEDULE: begin
        if (ev_count >= DEPTH) begin
          full = 1;
        end else begin
          due = tick_now() + 64'(longint'(delay));
          pos = ev_count;
          while (pos > 0 && $signed(ev_due[pos-1]) > $signed(due)) begin
            ev_due[pos] = ev_due[pos-1]; ev_kind[pos] = ev_kind[pos-1];
            ev_user[pos] = ev_user[pos-1];
            pos--;
          end
          ev_due[pos] = due; ev_kind[pos] = kind; ev_user[pos] = user;
          ev_count++;
        end
      end
      F_CANCEL_USER, F_CANCEL_KIND: begin
        for (int i = 0; i < ev_count; i++) begin
          if (ev_kind[i] == kind && (rq.fn == F_CANCEL_KIND || ev_user[i] == user)) begin
            drop_event(i);
            break;
          end
        end
      end
      F_ADD_TICKS: begin
        v = longint'(ticks_left) - tcount;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        ticks_left = int'(v);
      end
      F_IDLE: begin
        dc = ticks_left;
        if (limit != 0 && dc > limit) dc = limit;
        if (dc < 0) dc = 0;
        if (ev_count > 0 && dc > 0) begin
          done = longint'(slice_ticks) - longint'(ticks_left);
          if ($signed(ev_due[0]) <= $signed(global_ticks)) begin
            d = global_ticks - ev_due[0];
            gap = (d > 64'(GAP_LIMIT)) ? -GAP_LIMIT : -longint'(d);
          end else begin
            d = ev_due[0] - global_ticks;
            gap = (d > 64'(GAP_LIMIT)) ? GAP_LIMIT : longint'(d);
          end
          if (gap < done + dc) begin
            dc = gap - done;
            if (dc < 0) dc = 0;
          end
        end
        idle_sum += 64'(dc);
        ticks_left = int'(longint'(ticks_left) - dc);
      end
      F_ADVANCE: begin
        global_ticks += 64'(longint'(slice_ticks) - longint'(ticks_left));
        while (ev_count > 0 && $signed(ev_due[0]) <= $signed(global_ticks)) begin
          d = global_ticks - ev_due[0];
          push_result(1, ev_kind[0], ev_user[0], (d > 64'hFFFF_FFFF) ? '1 : d[31:0],
                      global_ticks, 0, 0, 0);
          drop_event(0);
        end
        slice_ticks = int'(max_slice);
        if (ev_count > 0) begin
          d = ev_due[0] - global_ticks;
          if (d < 64'(max_slice)) slice_ticks = int'(d);
        end
        ticks_left = slice_ticks;
      end
      F_FORCE: begin
        global_ticks += 64'(longint'(slice_ticks) - longint'(ticks_left));
        ticks_left = -1;
        slice_ticks = -1;
      end
      default: ev_count = 0;
    endcase
    push_result(0, 0, 0, 0, tick_now(), ticks_left, full, 1);
  endfunction

  function automatic request_t make_req(func_t fn, logic [31:0] delay, logic [5:0] kind,
                                        logic [63:0] user, logic [30:0] tcount,
                                        logic [30:0] limit);
    request_t rq;
    rq.fn = fn;
    rq.payload = {4'b0, limit, tcount, user, kind, delay};
    return rq;
  endfunction

  function automatic request_t random_req();
    int          pick;
    func_t       fn;
    logic [31:0] delay;
    logic [5:0]  kind;
    logic [63:0] user;
    logic [30:0] tcount, limit;
    pick = $urandom_range(99);
    if (pick < 35) fn = F_SCHEDULE;
    else if (pick < 43) fn = F_CANCEL_USER;
    else if (pick < 50) fn = F_CANCEL_KIND;
    else if (pick < 65) fn = F_ADD_TICKS;
    else if (pick < 75) fn = F_IDLE;
    else if (pick < 92) fn = F_ADVANCE;
    else if (pick < 96) fn = F_FORCE;
    else fn = F_CLEAR;
    pick = $urandom_range(99);
    if (pick < 70) delay = $urandom_range(320) - 20;
    else if (pick < 90) delay = $urandom;
    else delay = 0;
    kind = ($urandom_range(99) < 70) ? 6'($urandom_range(3)) : 6'($urandom);
    user = ($urandom_range(99) < 60) ? 64'($urandom_range(3)) : {$urandom, $urandom};
    pick = $urandom_range(99);
    tcount = (pick < 70) ? 31'($urandom_range(100)) : (pick < 90) ? 31'($urandom) : 31'd0;
    pick = $urandom_range(99);
    limit = (pick < 50) ? 31'd0 : (pick < 80) ? 31'($urandom_range(1, 100)) : 31'($urandom);
    return make_req(fn, delay, kind, user, tcount, limit);
  endfunction

  task automatic send(request_t rq);
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  // hold until every request went out and every result came back
  task automatic drain();
    while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_max_slice(logic [30:0] value);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    max_slice = value;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t rq;
        rq = pending_reqs.pop_front();
        predict_request(rq);
        s_tvalid <= 1;
        s_tdata <= rq.payload;
        s_tuser <= rq.fn;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: tdata=%h tuser=%b tlast=%b", m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        sched_result_t e;
        e = expected_results.pop_front();
        if (m_tuser !== e.rkind) begin
          $error("result_kind: expected %0d got %0d", e.rkind, m_tuser); errors++;
        end
        if (m_tdata[5:0] !== e.kind) begin
          $error("fired_kind: expected %0d got %0d", e.kind, m_tdata[5:0]); errors++;
        end
        if (m_tdata[69:6] !== e.user) begin
          $error("fired_user: expected %h got %h", e.user, m_tdata[69:6]); errors++;
        end
        if (m_tdata[101:70] !== e.late) begin
          $error("late_cycles: expected %0d got %0d", e.late, m_tdata[101:70]); errors++;
        end
        if (m_tdata[165:102] !== e.tick) begin
          $error("tick_now: expected %h got %h", e.tick, m_tdata[165:102]); errors++;
        end
        if (m_tdata[197:166] !== e.dcount) begin
          $error("downcount_now: expected %0d got %0d", $signed(e.dcount),
                 $signed(m_tdata[197:166]));
          errors++;
        end
        if (m_tdata[261:198] !== e.idle) begin
          $error("idle_total: expected %h got %h", e.idle, m_tdata[261:198]); errors++;
        end
        if (m_tdata[262] !== e.full) begin
          $error("queue_full: expected %0d got %0d", e.full, m_tdata[262]); errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last: expected %0d got %0d", e.last, m_tlast); errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [30:0] slice_settings[5];
    int          stall_modes[4][2];
    slice_settings = '{31'd1, 31'h7FFF_FFFF, 31'd0, 31'd20000, 31'd50};
    stall_modes = '{'{0, 0}, '{83, 0}, '{0, 83}, '{11, 11}};
    ev_count = 0;
    global_ticks = 0;
    idle_sum = 0;
    max_slice = MAX_SLICE_RESET;
    slice_ticks = int'(MAX_SLICE_RESET);
    ticks_left = int'(MAX_SLICE_RESET);
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, every command, full queue, saturation, past events
    send(make_req(F_SCHEDULE, 32'h8000_0000, 6'd0, '0, '0, '0));
    send(make_req(F_SCHEDULE, 32'h7FFF_FFFF, 6'd63, '1, '1, '1));
    send(make_req(F_SCHEDULE, 32'd100, 6'd5, 64'hA5A5, '0, '0));
    send(make_req(F_CANCEL_USER, '0, 6'd5, 64'hA5A4, '0, '0));
    send(make_req(F_CANCEL_USER, '0, 6'd5, 64'hA5A5, '0, '0));
    send(make_req(F_CANCEL_KIND, '0, 6'd63, '0, '0, '0));
    send(make_req(F_IDLE, '0, '0, '0, '0, 31'd0));
    send(make_req(F_ADVANCE, '0, '0, '0, '0, '0));
    send(make_req(F_ADD_TICKS, '0, '0, '0, 31'h7FFF_FFFF, '0));
    send(make_req(F_ADD_TICKS, '0, '0, '0, 31'h7FFF_FFFF, '0));
    send(make_req(F_IDLE, '0, '0, '0, '0, 31'd10));
    send(make_req(F_FORCE, '0, '0, '0, '0, '0));
    send(make_req(F_IDLE, '0, '0, '0, '0, '0));
    send(make_req(F_ADVANCE, '0, '0, '0, '0, '0));
    for (int i = 0; i < DEPTH + 1; i++)
      send(make_req(F_SCHEDULE, 32'(-i), 6'(i), 64'(i), '0, '0));
    send(make_req(F_IDLE, '0, '0, '0, '0, 31'd7));
    send(make_req(F_ADVANCE, '0, '0, '0, '0, '0));
    send(make_req(F_SCHEDULE, 32'd3, 6'd1, '0, '0, '0));
    send(make_req(F_CLEAR, '0, '0, '0, '0, '0));
    drain();

    // random phases, each under its own slice setting; handshake pressure cycles through four modes
    for (int p = 0; p < 5; p++) begin
      write_max_slice(slice_settings[p]);
      send_idle_pct = stall_modes[p % 4][0];
      recv_stall_pct = stall_modes[p % 4][1];
      for (int n = 0; n < 50; n++) send(random_req());
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tqs_pkg.sv
rtl/tqs_cell.sv
rtl/timed_event_queue_scheduler.sv
bench/tb_timed_event_queue_scheduler.sv
